// ----- src/cafm_pkg.sv -----
// Package for the configurable address field mapper.
// Holds the transaction structs, register and mode codes, the derived mapping
// struct and the shift helpers. No dependencies.
package cafm_pkg;

    localparam int FIELD_COUNT = 8;
    localparam int ORD_W       = 3;
    localparam int WID_W       = 6;
    localparam int OFF_W       = 6;
    localparam int VAL_W       = 32;
    localparam int ADDR_W      = 64;
    localparam int SHIFT_W     = $clog2(FIELD_COUNT * ((1 << WID_W) - 1) + 1);
    localparam int ORDERS_W    = FIELD_COUNT * ORD_W;
    localparam int WIDTHS_W    = FIELD_COUNT * WID_W;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 64;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_PAGE_OFFSET  = 2'd0;
    localparam logic [1:0] REG_HOST_OFFSET  = 2'd1;
    localparam logic [1:0] REG_FIELD_ORDERS = 2'd2;
    localparam logic [1:0] REG_FIELD_WIDTHS = 2'd3;

    // Reset values
    localparam logic [OFF_W-1:0]    RST_PAGE_OFFSET  = 6'd7;
    localparam logic [OFF_W-1:0]    RST_HOST_OFFSET  = 6'd7;
    localparam logic [ORDERS_W-1:0] RST_FIELD_ORDERS = 24'd11560031;
    localparam logic [WIDTHS_W-1:0] RST_FIELD_WIDTHS = 48'd44875983618176;

    // Field index of the half bank
    localparam int HALF_BANK_FIELD = 4;

    // Operation codes
    localparam logic [1:0] MODE_DECODE    = 2'd0;
    localparam logic [1:0] MODE_ENCODE    = 2'd1;
    localparam logic [1:0] MODE_MASK_HOST = 2'd2;
    localparam logic [1:0] MODE_MASK_PAGE = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [2:0]        field_select;
        logic [VAL_W-1:0]  channel_value;
        logic [VAL_W-1:0]  rank_value;
        logic [VAL_W-1:0]  bank_group_value;
        logic [VAL_W-1:0]  bank_value;
        logic [VAL_W-1:0]  half_bank_value;
        logic [VAL_W-1:0]  partition_value;
        logic [VAL_W-1:0]  row_value;
        logic [VAL_W-1:0]  column_value;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0] result;
        logic              config_error;
    } t_result;

    // Mapping derived from the registers, shared by lanes and merge stage
    typedef struct packed {
        logic [OFF_W-1:0]                      page_off;
        logic [OFF_W-1:0]                      host_off;
        logic [FIELD_COUNT-1:0][SHIFT_W-1:0]   lo;
        logic [FIELD_COUNT-1:0][SHIFT_W-1:0]   hi;
        logic                                  err;
    } t_map;

    // Left shift that yields zero at 64 or more
    function automatic logic [ADDR_W-1:0] shl64(logic [ADDR_W-1:0] v,
                                                logic [SHIFT_W-1:0] s);
        logic [ADDR_W-1:0] r;
        if (s >= SHIFT_W'(ADDR_W)) r = '0;
        else r = v << s[5:0];
        return r;
    endfunction

    // Right shift that yields zero at 64 or more
    function automatic logic [ADDR_W-1:0] shr64(logic [ADDR_W-1:0] v,
                                                logic [SHIFT_W-1:0] s);
        logic [ADDR_W-1:0] r;
        if (s >= SHIFT_W'(ADDR_W)) r = '0;
        else r = v >> s[5:0];
        return r;
    endfunction

endpackage

// ----- src/cafm_cfg.sv -----
// Register file and mapping precompute for the address field mapper.
// Holds the APB-style registers and registers the per-field shifts.
// Depends on cafm_pkg.
module cafm_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cafm_pkg::PADDR_W-1:0] paddr,
    input  logic [cafm_pkg::PDATA_W-1:0] pwdata,
    output logic [cafm_pkg::PDATA_W-1:0] prdata,
    output logic                         o_cfg_busy,
    output cafm_pkg::t_map               o_map
);

    logic [cafm_pkg::OFF_W-1:0]    r_page_off;
    logic [cafm_pkg::OFF_W-1:0]    r_host_off;
    logic [cafm_pkg::ORDERS_W-1:0] r_orders;
    logic [cafm_pkg::WIDTHS_W-1:0] r_widths;
    logic                          r_pend;
    cafm_pkg::t_map                r_map;
    cafm_pkg::t_map                n_map;
    logic                          w_wr;
    logic [1:0]                    w_idx;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[4:3];

    // Write registers; hold the block busy one cycle while the map settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_off <= cafm_pkg::RST_PAGE_OFFSET;
            r_host_off <= cafm_pkg::RST_HOST_OFFSET;
            r_orders   <= cafm_pkg::RST_FIELD_ORDERS;
            r_widths   <= cafm_pkg::RST_FIELD_WIDTHS;
            r_pend     <= 1'b1;
        end else begin
            r_pend <= w_wr;
            if (w_wr) begin
                case (w_idx)
                    cafm_pkg::REG_PAGE_OFFSET:  r_page_off <= pwdata[cafm_pkg::OFF_W-1:0];
                    cafm_pkg::REG_HOST_OFFSET:  r_host_off <= pwdata[cafm_pkg::OFF_W-1:0];
                    cafm_pkg::REG_FIELD_ORDERS: r_orders   <= pwdata[cafm_pkg::ORDERS_W-1:0];
                    cafm_pkg::REG_FIELD_WIDTHS: r_widths   <= pwdata[cafm_pkg::WIDTHS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            cafm_pkg::REG_PAGE_OFFSET:  prdata = cafm_pkg::PDATA_W'(r_page_off);
            cafm_pkg::REG_HOST_OFFSET:  prdata = cafm_pkg::PDATA_W'(r_host_off);
            cafm_pkg::REG_FIELD_ORDERS: prdata = cafm_pkg::PDATA_W'(r_orders);
            cafm_pkg::REG_FIELD_WIDTHS: prdata = cafm_pkg::PDATA_W'(r_widths);
            default:                    prdata = '0;
        endcase
    end

    // Sum lower- and same-order widths; flag bad orders or half bank width
    always_comb begin
        logic [cafm_pkg::ORD_W-1:0]   ord_j;
        logic [cafm_pkg::ORD_W-1:0]   ord_i;
        logic [cafm_pkg::SHIFT_W-1:0] wid_i;
        logic [cafm_pkg::SHIFT_W-1:0] lo;
        logic [cafm_pkg::SHIFT_W-1:0] same;
        logic [cafm_pkg::FIELD_COUNT-1:0] seen;
        n_map          = '0;
        n_map.page_off = r_page_off;
        n_map.host_off = r_host_off;
        seen           = '0;
        for (int j = 0; j < cafm_pkg::FIELD_COUNT; j++) begin
            ord_j = r_orders[j*cafm_pkg::ORD_W +: cafm_pkg::ORD_W];
            seen[ord_j] = 1'b1;
            lo   = '0;
            same = '0;
            for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) begin
                ord_i = r_orders[i*cafm_pkg::ORD_W +: cafm_pkg::ORD_W];
                wid_i = cafm_pkg::SHIFT_W'(r_widths[i*cafm_pkg::WID_W +: cafm_pkg::WID_W]);
                if (ord_i < ord_j)  lo   = lo + wid_i;
                if (ord_i == ord_j) same = same + wid_i;
            end
            n_map.lo[j] = lo;
            n_map.hi[j] = lo + same;
        end
        n_map.err = (~&seen) |
            (r_widths[cafm_pkg::HALF_BANK_FIELD*cafm_pkg::WID_W +: cafm_pkg::WID_W] > 6'd1);
    end

    always_ff @(posedge i_clk) begin
        r_map <= n_map;
    end

    assign o_map      = r_map;
    assign o_cfg_busy = r_pend;

endmodule

// ----- src/cafm_lane.sv -----
// One encode lane: places a field value at its shift in a 64-bit word.
// Registered output. Depends on cafm_pkg.
module cafm_lane (
    input  logic                         i_clk,
    input  logic [cafm_pkg::VAL_W-1:0]   i_value,
    input  logic [cafm_pkg::SHIFT_W-1:0] i_shift,
    output logic [cafm_pkg::ADDR_W-1:0]  o_part
);

    logic [cafm_pkg::ADDR_W-1:0] r_part;

    // Shift the unmasked value into place
    always_ff @(posedge i_clk) begin
        r_part <= cafm_pkg::shl64(cafm_pkg::ADDR_W'(i_value), i_shift);
    end

    assign o_part = r_part;

endmodule

// ----- src/cafm_merge.sv -----
// Merge stage: combines lane words for encode and handles decode and masking.
// Registered result with strobe. Depends on cafm_pkg.
module cafm_merge (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_vld,
    input  logic [1:0]                                        i_mode,
    input  logic [cafm_pkg::ADDR_W-1:0]                       i_addr,
    input  logic [2:0]                                        i_sel,
    input  logic [cafm_pkg::FIELD_COUNT-1:0][cafm_pkg::ADDR_W-1:0] i_parts,
    input  cafm_pkg::t_map                                    i_map,
    output logic                                              o_valid,
    output cafm_pkg::t_result                                 o_result
);

    logic                        r_valid;
    cafm_pkg::t_result           r_result;
    logic [cafm_pkg::ADDR_W-1:0] n_res;

    // Select the result per mode
    always_comb begin
        logic [cafm_pkg::ADDR_W-1:0]  merged;
        logic [cafm_pkg::ADDR_W-1:0]  dec;
        logic [cafm_pkg::SHIFT_W-1:0] hi;
        merged = '0;
        for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) begin
            merged = merged | i_parts[i];
        end
        hi  = i_map.hi[i_sel];
        dec = i_addr >> i_map.page_off;
        if (hi < cafm_pkg::SHIFT_W'(cafm_pkg::ADDR_W)) begin
            dec = dec & ~({cafm_pkg::ADDR_W{1'b1}} << hi[5:0]);
        end
        dec = cafm_pkg::shr64(dec, i_map.lo[i_sel]);
        case (i_mode)
            cafm_pkg::MODE_DECODE:    n_res = dec;
            cafm_pkg::MODE_ENCODE:    n_res = merged << i_map.page_off;
            cafm_pkg::MODE_MASK_HOST: n_res = i_addr & ({cafm_pkg::ADDR_W{1'b1}} << i_map.host_off);
            cafm_pkg::MODE_MASK_PAGE: n_res = i_addr & ({cafm_pkg::ADDR_W{1'b1}} << i_map.page_off);
            default:                  n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.result       <= n_res;
        r_result.config_error <= i_map.err;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- src/configurable_address_field_mapper.sv -----
// Top level of the configurable address field mapper.
// Depends on cafm_pkg, cafm_cfg, cafm_lane and cafm_merge.
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high and
//   busy low. i_item carries mode, address, field select and eight field values.
//   Output channel: o_valid strobes for one cycle with o_result (result word and
//   config_error flag). The receiver cannot stall; results are never held.
//   Pipeline: lanes and stage 1, then merge. Throughput: one transaction per
//   cycle while busy is low; eight encode lanes each place one field value, and
//   the merge stage ORs them and also performs decode and offset masking.
//   Configuration: APB-style port, 64-bit data, register i at byte address 8*i.
//   busy is high for the cycle after any register write (and after reset)
//   while the per-field shifts are recomputed and registered.
//   Reset: synchronous, active low; registers return to their default mapping,
//   the pipeline empties and busy is high for one cycle.
module configurable_address_field_mapper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cafm_pkg::t_item              i_item,
    output logic                         o_valid,
    output cafm_pkg::t_result            o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cafm_pkg::PADDR_W-1:0] paddr,
    input  logic [cafm_pkg::PDATA_W-1:0] pwdata,
    output logic [cafm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    cafm_pkg::t_map                                         w_map;
    logic                                                   w_cfg_busy;
    logic                                                   w_accept;
    logic [cafm_pkg::FIELD_COUNT-1:0][cafm_pkg::VAL_W-1:0]  w_vals;
    logic [cafm_pkg::FIELD_COUNT-1:0][cafm_pkg::ADDR_W-1:0] w_parts;
    logic                                                   r_s1_vld;
    logic [1:0]                                             r_s1_mode;
    logic [cafm_pkg::ADDR_W-1:0]                            r_s1_addr;
    logic [2:0]                                             r_s1_sel;

    assign pready   = 1'b1;
    assign busy     = w_cfg_busy;
    assign w_accept = start & ~busy;

    cafm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .o_cfg_busy (w_cfg_busy),
        .o_map      (w_map)
    );

    // Gather field values in field order
    assign w_vals[0] = i_item.channel_value;
    assign w_vals[1] = i_item.rank_value;
    assign w_vals[2] = i_item.bank_group_value;
    assign w_vals[3] = i_item.bank_value;
    assign w_vals[4] = i_item.half_bank_value;
    assign w_vals[5] = i_item.partition_value;
    assign w_vals[6] = i_item.row_value;
    assign w_vals[7] = i_item.column_value;

    // Encode lanes
    for (genvar g = 0; g < cafm_pkg::FIELD_COUNT; g++) begin : g_lane
        cafm_lane u_lane (
            .i_clk   (i_clk),
            .i_value (w_vals[g]),
            .i_shift (w_map.lo[g]),
            .o_part  (w_parts[g])
        );
    end

    // Stage 1: capture the transaction alongside the lane words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mode <= i_item.mode;
        r_s1_addr <= i_item.address;
        r_s1_sel  <= i_item.field_select;
    end

    cafm_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_s1_vld),
        .i_mode   (r_s1_mode),
        .i_addr   (r_s1_addr),
        .i_sel    (r_s1_sel),
        .i_parts  (w_parts),
        .i_map    (w_map),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Every accepted transaction yields exactly one strobe, via stage 1 and merge
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_valid)
        else $error("result strobe missing after accepted transaction");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 2))
        else $error("result strobe without accepted transaction");

    // A register write blocks new transactions while the map settles
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> busy)
        else $error("transaction could enter before mapping settled");

endmodule

// ----- bench/configurable_address_field_mapper_test.sv -----
// Self-checking testbench for configurable_address_field_mapper.
// It predicts each transaction from its own copy of the mapping registers and
// sweeps several register settings. Depends on cafm_pkg and the mapper RTL.
`timescale 1ns / 100ps

module configurable_address_field_mapper_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 175;
    localparam int DRAIN_CYCLES  = 4;

    // Clock, reset and block ports
    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           start     = 1'b0;
    logic                           busy;
    cafm_pkg::t_item                i_item    = '0;
    logic                           o_valid;
    cafm_pkg::t_result              o_result;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [cafm_pkg::PADDR_W-1:0]   paddr     = '0;
    logic [cafm_pkg::PDATA_W-1:0]   pwdata    = '0;
    logic [cafm_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Mapping registers as the checker sees them
    logic [cafm_pkg::OFF_W-1:0]     page_off_cfg  = cafm_pkg::RST_PAGE_OFFSET;
    logic [cafm_pkg::OFF_W-1:0]     host_off_cfg  = cafm_pkg::RST_HOST_OFFSET;
    logic [cafm_pkg::ORDERS_W-1:0]  orders_cfg    = cafm_pkg::RST_FIELD_ORDERS;
    logic [cafm_pkg::WIDTHS_W-1:0]  widths_cfg    = cafm_pkg::RST_FIELD_WIDTHS;

    cafm_pkg::t_item                pending_requests[$];
    cafm_pkg::t_result              expected_results[$];
    int                             sender_idle_pct = 0;
    int                             mismatch_count  = 0;
    int                             cycle_count     = 0;

    configurable_address_field_mapper u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int order_of(int f);
        return int'(orders_cfg[cafm_pkg::ORD_W*f +: cafm_pkg::ORD_W]);
    endfunction

    function automatic int width_of(int f);
        return int'(widths_cfg[cafm_pkg::WID_W*f +: cafm_pkg::WID_W]);
    endfunction

    // Sum of the widths of every field ordered strictly below ord
    function automatic int bits_below(int ord);
        int sum;
        sum = 0;
        for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) begin
            if (order_of(i) < ord) sum += width_of(i);
        end
        return sum;
    endfunction

    // Work out the mapper's answer for one transaction
    function automatic cafm_pkg::t_result map_address(cafm_pkg::t_item it);
        cafm_pkg::t_result                r;
        logic [cafm_pkg::ADDR_W-1:0]      word;
        logic [cafm_pkg::VAL_W-1:0]       vals[cafm_pkg::FIELD_COUNT];
        logic [cafm_pkg::FIELD_COUNT-1:0] seen;
        int                               ord, lo, hi, sh;
        word = '0;
        vals = '{it.channel_value, it.rank_value, it.bank_group_value, it.bank_value,
                 it.half_bank_value, it.partition_value, it.row_value, it.column_value};
        case (it.mode)
            cafm_pkg::MODE_DECODE: begin
                ord = order_of(int'(it.field_select));
                lo  = bits_below(ord);
                hi  = lo;
                for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) begin
                    if (order_of(i) == ord) hi += width_of(i);
                end
                word = it.address >> page_off_cfg;
                if (hi < cafm_pkg::ADDR_W) word &= (64'd1 << hi) - 64'd1;
                word = (lo >= cafm_pkg::ADDR_W) ? '0 : (word >> lo);
            end
            cafm_pkg::MODE_ENCODE: begin
                for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) begin
                    sh = bits_below(order_of(i));
                    if (sh < cafm_pkg::ADDR_W) word |= cafm_pkg::ADDR_W'(vals[i]) << sh;
                end
                word = word << page_off_cfg;
            end
            cafm_pkg::MODE_MASK_HOST: word = it.address & ~((64'd1 << host_off_cfg) - 64'd1);
            default:        word = it.address & ~((64'd1 << page_off_cfg) - 64'd1);
        endcase
        seen = '0;
        for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) seen[order_of(i)] = 1'b1;
        r.result       = word;
        r.config_error = (seen != '1) || (width_of(cafm_pkg::HALF_BANK_FIELD) > 1);
        return r;
    endfunction

    function automatic cafm_pkg::t_item random_item();
        cafm_pkg::t_item it;
        it.mode = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       it.address = '0;
            1:       it.address = '1;
            default: it.address = {$urandom, $urandom};
        endcase
        it.field_select = 3'($urandom_range(0, 7));
        it.channel_value    = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        it.rank_value       = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        it.bank_group_value = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        it.bank_value       = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        it.half_bank_value  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        it.partition_value  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        it.row_value        = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        it.column_value     = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255);
        return it;
    endfunction

    // Request driver: hold a transaction while busy, otherwise maybe idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_results.push_back(map_address(i_item));
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_requests.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                i_item <= pending_requests.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: compare each strobe with the oldest prediction
    always @(posedge i_clk) begin : result_check
        cafm_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding: result %h config_error %b",
                       o_result.result, o_result.config_error);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.result !== want.result) begin
                    $error("result: expected %h, actual %h", want.result, o_result.result);
                    mismatch_count++;
                end
                if (o_result.config_error !== want.config_error) begin
                    $error("config_error: expected %b, actual %b",
                           want.config_error, o_result.config_error);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold until every queued transaction has been taken and answered
    task automatic wait_drained();
        while (pending_requests.size() != 0 || start || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_register(input logic [1:0] index,
                                  input logic [cafm_pkg::PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            cafm_pkg::REG_PAGE_OFFSET:  page_off_cfg = value[cafm_pkg::OFF_W-1:0];
            cafm_pkg::REG_HOST_OFFSET:  host_off_cfg = value[cafm_pkg::OFF_W-1:0];
            cafm_pkg::REG_FIELD_ORDERS: orders_cfg   = value[cafm_pkg::ORDERS_W-1:0];
            default:                    widths_cfg   = value[cafm_pkg::WIDTHS_W-1:0];
        endcase
    endtask

    task automatic run_phase(input logic [cafm_pkg::OFF_W-1:0] page,
                             input logic [cafm_pkg::OFF_W-1:0] host,
                             input logic [cafm_pkg::ORDERS_W-1:0] orders,
                             input logic [cafm_pkg::WIDTHS_W-1:0] widths,
                             input int idle_pct);
        wait_drained();
        write_register(cafm_pkg::REG_PAGE_OFFSET, cafm_pkg::PDATA_W'(page));
        write_register(cafm_pkg::REG_HOST_OFFSET, cafm_pkg::PDATA_W'(host));
        write_register(cafm_pkg::REG_FIELD_ORDERS, cafm_pkg::PDATA_W'(orders));
        write_register(cafm_pkg::REG_FIELD_WIDTHS, cafm_pkg::PDATA_W'(widths));
        sender_idle_pct = idle_pct;
        repeat (RANDOM_ITEMS) pending_requests.push_back(random_item());
        wait_drained();
    endtask

    // Mostly a legal permutation with modest widths; sometimes anything goes
    task automatic random_phase(input int idle_pct);
        logic [cafm_pkg::ORDERS_W-1:0] orders;
        logic [cafm_pkg::WIDTHS_W-1:0] widths;
        int                            perm[cafm_pkg::FIELD_COUNT];
        int                            j, tmp;
        for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) perm[i] = i;
        for (int i = cafm_pkg::FIELD_COUNT - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < cafm_pkg::FIELD_COUNT; i++) begin
            orders[cafm_pkg::ORD_W*i +: cafm_pkg::ORD_W] = cafm_pkg::ORD_W'(perm[i]);
            widths[cafm_pkg::WID_W*i +: cafm_pkg::WID_W] =
                cafm_pkg::WID_W'($urandom_range(0, 10));
        end
        widths[cafm_pkg::WID_W*cafm_pkg::HALF_BANK_FIELD +: cafm_pkg::WID_W] =
            cafm_pkg::WID_W'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) orders = cafm_pkg::ORDERS_W'($urandom);
        if ($urandom_range(0, 3) == 0) widths = cafm_pkg::WIDTHS_W'({$urandom, $urandom});
        run_phase(cafm_pkg::OFF_W'($urandom_range(0, 63)),
                  cafm_pkg::OFF_W'($urandom_range(0, 63)),
                  orders, widths, idle_pct);
    endtask

    // Stimulus sequence
    initial begin : stimulus
        cafm_pkg::t_item it;
        int              idle_choice[3];
        idle_choice = '{0, 59, 9};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed transactions, then random ones, under the reset mapping
        for (int s = 0; s < cafm_pkg::FIELD_COUNT; s++) begin
            it = random_item();
            it.mode         = cafm_pkg::MODE_DECODE;
            it.address      = '1;
            it.field_select = 3'(s);
            pending_requests.push_back(it);
        end
        it = random_item();
        it.mode = cafm_pkg::MODE_DECODE;
        it.address = '0;
        pending_requests.push_back(it);
        it.field_select = 3'd7;
        it.address = 64'h8000_0000_0000_0001;
        pending_requests.push_back(it);
        it.mode = cafm_pkg::MODE_ENCODE;
        {it.channel_value, it.rank_value, it.bank_group_value, it.bank_value,
         it.half_bank_value, it.partition_value, it.row_value, it.column_value} = '1;
        pending_requests.push_back(it);
        {it.channel_value, it.rank_value, it.bank_group_value, it.bank_value,
         it.half_bank_value, it.partition_value, it.row_value, it.column_value} = '0;
        pending_requests.push_back(it);
        {it.channel_value, it.rank_value, it.bank_group_value, it.bank_value,
         it.half_bank_value, it.partition_value, it.row_value, it.column_value} =
            {32'd1, 32'd2, 32'd3, 32'd4, 32'd1, 32'd5, 32'd6, 32'd7};
        pending_requests.push_back(it);
        it.mode = cafm_pkg::MODE_MASK_HOST;
        it.address = '1;
        pending_requests.push_back(it);
        it.address = '0;
        pending_requests.push_back(it);
        it.mode = cafm_pkg::MODE_MASK_PAGE;
        pending_requests.push_back(it);
        it.address = '1;
        pending_requests.push_back(it);
        repeat (RANDOM_ITEMS - 25) pending_requests.push_back(random_item());
        wait_drained();

        // Extreme settings: no offsets and a plain field order
        run_phase('0, '0, 24'o76543210, {cafm_pkg::FIELD_COUNT{6'd8}}, 59);
        // Every order shared, widest fields, largest offsets
        run_phase('1, '1, '0, '1, 9);
        // Every order the highest, zero widths
        run_phase(6'd12, 6'd40, '1, '0, 0);
        // Reverse order, half bank one bit wide
        run_phase(6'd7, 6'd3, 24'o01234567,
                  {6'd9, 6'd14, 6'd2, 6'd1, 6'd3, 6'd2, 6'd1, 6'd2}, 59);
        for (int p = 0; p < 6; p++) random_phase(idle_choice[p % 3]);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
